/* hw/rtl/rbsi_pkg.sv */
// Package: shared types, constants and widths for the ray/box slab intersect block.
package rbsi_pkg;
  localparam int unsigned QW = 32;
  localparam int unsigned FRAC = 16;
  localparam int unsigned DIFFW = QW + 1;
  localparam int unsigned NUMW = DIFFW + FRAC;
  localparam int unsigned DIVSTEPS = NUMW;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_TDATA_W = 6 * QW;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [QW-1:0] T_NONE = -32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [QW-1:0] lo;
    logic signed [QW-1:0] hi;
  } slab_t;

  typedef struct packed {
    logic [2:0][QW-1:0] loc;
    logic [2:0][QW-1:0] dir;
    logic [2:0][QW-1:0] plane;
    logic [2:0]         cand;
  } ray_ctx_t;
endpackage

/* hw/rtl/rbsi_div.sv */
// Pipelined restoring divider: one quotient bit per stage, truncated and saturated to Q16.16.
module rbsi_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [rbsi_pkg::DIFFW-1:0] diff,
  input  logic signed [rbsi_pkg::QW-1:0]    dvs,
  output logic signed [rbsi_pkg::QW-1:0]    quo
);
  import rbsi_pkg::*;

  localparam int unsigned N = DIVSTEPS;

  logic [N-1:0]   num_r [0:N];
  logic [N-1:0]   q_r   [0:N];
  logic [QW:0]    rem_r [0:N];
  logic [QW-1:0]  den_r [0:N];
  logic           neg_r [0:N];
  logic [DIFFW-1:0] adiff;
  logic [QW-1:0]    advs;
  logic [N:0]       qmag;
  logic signed [N+1:0] qs;

  assign adiff = diff[DIFFW-1] ? DIFFW'(-diff) : DIFFW'(diff);
  assign advs  = dvs[QW-1] ? QW'(-dvs) : QW'(dvs);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r[0] <= {adiff, {FRAC{1'b0}}};
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      den_r[0] <= advs;
      neg_r[0] <= diff[DIFFW-1] ^ dvs[QW-1];
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [QW+1:0] trial;
    logic [QW+1:0] sub;
    assign trial = {rem_r[s], num_r[s][N-1]};
    assign sub   = trial - {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[s+1] <= {num_r[s][N-2:0], 1'b0};
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        if (!sub[QW+1]) begin
          rem_r[s+1] <= sub[QW:0];
          q_r[s+1]   <= {q_r[s][N-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= trial[QW:0];
          q_r[s+1]   <= {q_r[s][N-2:0], 1'b0};
        end
      end
    end
  end

  assign qmag = {1'b0, q_r[N]};
  assign qs   = neg_r[N] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_comb begin
    if (qs > $signed((N+2)'(33'sh0_7FFF_FFFF))) quo = 32'sh7FFF_FFFF;
    else if (qs < -$signed((N+2)'(34'sh0_8000_0000))) quo = 32'sh8000_0000;
    else quo = qs[QW-1:0];
  end
endmodule

/* hw/rtl/ray_box_slab_intersect.sv */
// Top level: ray against axis-aligned box, slab test in a deep pipeline.
// Stages from input transaction to result: setup, divider load, 49 divider stages,
// select, multiply, check. Throughput: one transaction per cycle unless the output is held.
// Whole pipeline stalls together when the output is held; nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and loads bounds of -1.0 to 1.0 on every axis.
module ray_box_slab_intersect (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbsi_pkg::QW-1:0]          cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
  input  logic [rbsi_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit, entry_param, hit_x, hit_y, hit_z, face_axis, face_positive, zero pad
  output logic [rbsi_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rbsi_pkg::*;

  localparam int unsigned DL = DIVSTEPS + 1;
  localparam int unsigned CRDW = 2*QW - FRAC + 1;

  logic signed [QW-1:0] bmin_r [3];
  logic signed [QW-1:0] bmax_r [3];
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bmin_r[i] <= T_NONE;
        bmax_r[i] <= Q_ONE;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: bmin_r[0] <= cfg_data;
        REG_MIN_Y: bmin_r[1] <= cfg_data;
        REG_MIN_Z: bmin_r[2] <= cfg_data;
        REG_MAX_X: bmax_r[0] <= cfg_data;
        REG_MAX_Y: bmax_r[1] <= cfg_data;
        REG_MAX_Z: bmax_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: classify
  ray_ctx_t ctx_nxt, ctx_r;
  logic [2:0][DIFFW-1:0] diff_nxt, diff_r;
  logic v0_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [QW-1:0] o, d;
      o = in_tdata[i*QW +: QW];
      d = in_tdata[(i+3)*QW +: QW];
      ctx_nxt.loc[i] = o;
      ctx_nxt.dir[i] = d;
      ctx_nxt.plane[i] = '0;
      if (o < bmin_r[i]) ctx_nxt.plane[i] = bmin_r[i];
      else if (o > bmax_r[i]) ctx_nxt.plane[i] = bmax_r[i];
      ctx_nxt.cand[i] = ((o < bmin_r[i]) || (o > bmax_r[i])) && (d != '0);
      diff_nxt[i] = DIFFW'($signed(ctx_nxt.plane[i])) - DIFFW'(o);
    end
  end

  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r  <= ctx_nxt;
      diff_r <= diff_nxt;
    end
  end

  // divider stages
  logic signed [QW-1:0] tq [3];
  for (genvar a = 0; a < 3; a++) begin : g_div
    rbsi_div u_div (
      .clk (clk), .adv (adv), .diff (diff_r[a]), .dvs (ctx_r.dir[a]), .quo (tq[a])
    );
  end

  ray_ctx_t ctxd_r [DL];
  logic [DL-1:0] vd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else if (adv) vd_r <= {vd_r[DL-2:0], v0_r};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ctxd_r[0] <= ctx_r;
      for (int s = 1; s < DL; s++) ctxd_r[s] <= ctxd_r[s-1];
    end
  end
  ray_ctx_t cd;
  assign cd = ctxd_r[DL-1];

  // select stage
  logic signed [QW-1:0] tc [3];
  logic signed [QW-1:0] t_nxt, t_r;
  logic [1:0] best_nxt, best_r;
  logic vs_r;
  ray_ctx_t cs_r;
  always_comb begin
    for (int i = 0; i < 3; i++) tc[i] = cd.cand[i] ? tq[i] : T_NONE;
    best_nxt = 2'd0;
    t_nxt = tc[0];
    for (int i = 1; i < 3; i++)
      if (t_nxt < tc[i]) begin
        t_nxt = tc[i];
        best_nxt = 2'(i);
      end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else if (adv) vs_r <= vd_r[DL-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r <= t_nxt; best_r <= best_nxt; cs_r <= cd;
    end
  end

  // multiply stage
  logic signed [2*QW-1:0] prod_r [3];
  logic signed [QW-1:0] t2_r;
  logic [1:0] best2_r;
  logic vm_r;
  ray_ctx_t cm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (adv) vm_r <= vs_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) prod_r[i] <= t_r * $signed(cs_r.dir[i]);
      t2_r <= t_r; best2_r <= best_r; cm_r <= cs_r;
    end
  end

  // check stage
  logic signed [CRDW-1:0] crd [3];
  logic miss;
  logic [OUT_TDATA_W-1:0] res_nxt, res_r;
  logic vo_r;
  always_comb begin
    miss = t2_r < 0;
    for (int i = 0; i < 3; i++) begin
      crd[i] = CRDW'($signed(cm_r.loc[i]) + (prod_r[i] >>> FRAC));
      if (2'(i) != best2_r) begin
        if (crd[i] < bmin_r[i] || crd[i] > bmax_r[i]) miss = 1'b1;
      end else crd[i] = CRDW'($signed(cm_r.plane[i]));
    end
    res_nxt = '0;
    if (!miss) begin
      res_nxt[0]      = 1'b1;
      res_nxt[31:1]   = t2_r[30:0];
      res_nxt[63:32]  = crd[0][QW-1:0];
      res_nxt[95:64]  = crd[1][QW-1:0];
      res_nxt[127:96] = crd[2][QW-1:0];
      res_nxt[129:128] = best2_r;
      res_nxt[130]    = cm_r.plane[best2_r] == bmax_r[best2_r];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  assign adv = !vo_r || out_tready;
  assign out_tvalid = vo_r;
  assign out_tdata = res_r;
endmodule
